### rtl/delimiter_keep_char_filter_assert.svh
// assertion macros for the delimiter keep character filter
// used by the top level only; the macros expand to nothing when SYNTHESIS is defined
`ifndef DELIMITER_KEEP_CHAR_FILTER_ASSERT_SVH
`define DELIMITER_KEEP_CHAR_FILTER_ASSERT_SVH

`ifndef SYNTHESIS

// when cond holds at a clock edge, expr must hold at the same edge
`define DKCF_ASSERT_IMPLY(lbl, clk, rst_n, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("implication check failed");

// cond must never hold at a clock edge
`define DKCF_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define DKCF_ASSERT_IMPLY(lbl, clk, rst_n, cond, expr)
`define DKCF_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

### rtl/dkcf_pkg.sv
// shared types, constants and helper functions of the delimiter keep character filter
// no dependencies; imported by every module of the block
`default_nettype none

package dkcf_pkg;

    localparam int DELIM_MAX   = 4;
    localparam int POS_W       = $clog2(DELIM_MAX + 1);
    localparam int IDX_W       = $clog2(DELIM_MAX);
    localparam int HOLD_W      = $clog2(DELIM_MAX);
    localparam int LEN_W       = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_DATA_W-1:0] DELIM_BYTES_RST = 32'd44;
    localparam logic [LEN_W-1:0]      DELIM_LEN_RST   = 3'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELIM_BYTES = 2'd0,
        REG_DELIM_LEN   = 2'd1,
        REG_HEX_MODE    = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_last;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       stream_end;
    } t_out_word;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] delim_bytes;
        logic [LEN_W-1:0]      delim_len;
        logic                  hex_mode;
    } t_cfg;

    // one accepted byte's worth of results: window bytes plus a keep mask
    typedef struct packed {
        logic [DELIM_MAX-1:0][7:0] bytes;
        logic [DELIM_MAX-1:0]      keep;
        logic                      stream_last;
    } t_bundle;

    function automatic logic is_number_char(input logic [7:0] c, input logic hex);
        logic digit;
        digit = (c >= 8'h30) && (c <= 8'h39);
        if (hex) begin
            return digit || ((c >= 8'h41) && (c <= 8'h46)) || ((c >= 8'h61) && (c <= 8'h66));
        end
        return digit || (c == 8'h2b) || (c == 8'h2d) || (c == 8'h2e)
            || (c == 8'h45) || (c == 8'h65);
    endfunction

    // length in use: zero acts as one, anything above the maximum as the maximum
    function automatic logic [POS_W-1:0] eff_len(input logic [LEN_W-1:0] l);
        if (l == '0) begin
            return POS_W'(1);
        end else if (int'(l) > DELIM_MAX) begin
            return POS_W'(DELIM_MAX);
        end
        return POS_W'(l);
    endfunction

endpackage

`default_nettype wire

### rtl/delimiter_keep_char_filter.sv
// delimiter keep character filter: top level with configuration registers
// depends on dkcf_pkg, dkcf_front, dkcf_fifo, dkcf_back and the assertion header
//
// usage
// - input channel (i_in_valid / o_in_ready / i_in_word): one text byte per word,
//   stream_last set on the final byte of a text
// - output channel (o_out_valid / i_out_ready / o_out_word): kept number characters
//   and matched delimiter bytes in stream order; run_last flags the last word caused
//   by one input byte, stream_end the last word of a text; a text whose flush keeps
//   nothing ends with one empty marker word (byte_valid low)
// - config port (i_cfg_we / i_cfg_idx / i_cfg_data): delimiter bytes, delimiter
//   length (zero acts as one, above four as four), hex mode; write only while idle
// - a byte's words are read from the registered queue, not straight from the input
// - throughput: one input byte per cycle while the queue is not full; the delimiter
//   compare and window shift for one byte are combinational in the front part;
//   the back part sends one word per cycle while i_out_ready is high, so a byte
//   with several words keeps the output busy for each; four queue slots absorb the burst
// - bytes that cause no word (dropped characters, held lookahead) take no queue slot
// - reset: window empty, queue empty, delimiter ',' of length one, decimal mode
// - output stall: the queue fills and o_in_ready drops; nothing is lost or repeated
`default_nettype none

`include "delimiter_keep_char_filter_assert.svh"

module delimiter_keep_char_filter import dkcf_pkg::*; #(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_word              i_in_word,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_word                  o_out_word,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration registers
    logic [CFG_DATA_W-1:0] r_delim_bytes;
    logic [LEN_W-1:0]      r_delim_len;
    logic                  r_hex_mode;
    t_cfg                  w_cfg;

    // front to queue and queue to back
    logic    w_push;
    logic    w_full;
    t_bundle w_push_data;
    logic    w_pop;
    logic    w_empty;
    t_bundle w_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim_bytes <= DELIM_BYTES_RST;
            r_delim_len   <= DELIM_LEN_RST;
            r_hex_mode    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_DELIM_BYTES: r_delim_bytes <= i_cfg_data;
                REG_DELIM_LEN:   r_delim_len   <= i_cfg_data[LEN_W-1:0];
                REG_HEX_MODE:    r_hex_mode    <= i_cfg_data[0];
                default: begin
                    // unmapped index, write is dropped
                end
            endcase
        end
    end

    assign w_cfg.delim_bytes = r_delim_bytes;
    assign w_cfg.delim_len   = r_delim_len;
    assign w_cfg.hex_mode    = r_hex_mode;

    // window, delimiter match and character test
    dkcf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_bundle   (w_push_data)
    );

    // decouples byte intake from word delivery
    dkcf_fifo #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_head),
        .o_empty (w_empty)
    );

    // serializes each bundle into output words
    dkcf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data      (w_head),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    // an empty marker only ever closes a text and carries a zero byte
    `DKCF_ASSERT_IMPLY(a_marker_closes, i_clk, i_rst_n, o_out_valid && !o_out_word.byte_valid, o_out_word.run_last && o_out_word.stream_end && (o_out_word.out_byte == 8'h00))
    // the end of a text is also the end of its byte's run
    `DKCF_ASSERT_IMPLY(a_end_is_run_last, i_clk, i_rst_n, o_out_valid && o_out_word.stream_end, o_out_word.run_last)
    // the front never pushes into a full queue
    `DKCF_ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, w_push && w_full)

endmodule

`default_nettype wire

### rtl/dkcf_front.sv
// front part: holds the lookahead window, matches the delimiter and marks kept bytes
// depends on dkcf_pkg; pushes a bundle per accepted word that keeps bytes or ends text
`default_nettype none

module dkcf_front import dkcf_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cfg     i_cfg,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_word i_in_word,
    input  wire logic     i_full,
    output logic          o_push,
    output t_bundle       o_bundle
);

    logic [DELIM_MAX-2:0][7:0] r_win;
    logic [HOLD_W-1:0]         r_count;
    logic [DELIM_MAX-2:0][7:0] n_win;
    logic [HOLD_W-1:0]         n_count;

    logic [DELIM_MAX-1:0][7:0] w;
    logic [DELIM_MAX-1:0][7:0] dl;
    logic [DELIM_MAX-1:0]      keep;
    logic                      accept;

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        logic [POS_W-1:0] m;
        logic [POS_W-1:0] p;
        logic [POS_W-1:0] len;
        logic [POS_W-1:0] idx;
        logic             hit;

        len = eff_len(i_cfg.delim_len);
        m   = POS_W'(r_count) + POS_W'(1);
        hit = 1'b0;
        idx = '0;

        // window with the new byte appended
        for (int j = 0; j < DELIM_MAX - 1; j++) begin
            if (POS_W'(j) < POS_W'(r_count)) begin
                w[j] = r_win[j];
            end else if (POS_W'(j) == POS_W'(r_count)) begin
                w[j] = i_in_word.in_byte;
            end else begin
                w[j] = 8'h00;
            end
        end
        w[DELIM_MAX-1] = (POS_W'(r_count) == POS_W'(DELIM_MAX - 1)) ? i_in_word.in_byte : 8'h00;

        for (int k = 0; k < DELIM_MAX; k++) begin
            dl[k] = i_cfg.delim_bytes[8*k +: 8];
        end

        // compare from the oldest byte while a full delimiter still fits
        p    = '0;
        keep = '0;
        for (int s = 0; s < DELIM_MAX; s++) begin
            if ((m - p) >= len) begin
                hit = 1'b1;
                for (int k = 0; k < DELIM_MAX; k++) begin
                    idx = p + POS_W'(k);
                    if ((POS_W'(k) < len) && (idx < POS_W'(DELIM_MAX))) begin
                        if (w[idx[IDX_W-1:0]] != dl[k]) begin
                            hit = 1'b0;
                        end
                    end
                end
                if (hit) begin
                    for (int k = 0; k < DELIM_MAX; k++) begin
                        idx = p + POS_W'(k);
                        if ((POS_W'(k) < len) && (idx < POS_W'(DELIM_MAX))) begin
                            keep[idx[IDX_W-1:0]] = 1'b1;
                        end
                    end
                    p = p + len;
                end else begin
                    if (is_number_char(w[p[IDX_W-1:0]], i_cfg.hex_mode)) begin
                        keep[p[IDX_W-1:0]] = 1'b1;
                    end
                    p = p + POS_W'(1);
                end
            end
        end

        // end of stream: leftover bytes go through the character test alone
        if (i_in_word.stream_last) begin
            for (int j = 0; j < DELIM_MAX; j++) begin
                if ((POS_W'(j) >= p) && (POS_W'(j) < m)
                    && is_number_char(w[j], i_cfg.hex_mode)) begin
                    keep[j] = 1'b1;
                end
            end
        end

        // leftover bytes move to the front of the window
        for (int j = 0; j < DELIM_MAX - 1; j++) begin
            idx = p + POS_W'(j);
            n_win[j] = (idx < POS_W'(DELIM_MAX)) ? w[idx[IDX_W-1:0]] : 8'h00;
        end
        n_count = i_in_word.stream_last ? '0 : HOLD_W'(m - p);
    end

    assign o_push               = accept && ((keep != '0) || i_in_word.stream_last);
    assign o_bundle.bytes       = w;
    assign o_bundle.keep        = keep;
    assign o_bundle.stream_last = i_in_word.stream_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (accept) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win <= n_win;
        end
    end

endmodule

`default_nettype wire

### rtl/dkcf_fifo.sv
// short bundle queue between the front and back parts
// depends on dkcf_pkg for the bundle type
`default_nettype none

module dkcf_fifo import dkcf_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_bundle i_data,
    output logic         o_full,
    input  wire logic    i_pop,
    output t_bundle      o_data,
    output logic         o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_bundle          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

### rtl/dkcf_back.sv
// back part: walks the keep mask of the head bundle and sends one word per cycle while i_out_ready is high
// depends on dkcf_pkg; pops the queue after the bundle's last word
`default_nettype none

module dkcf_back import dkcf_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_bundle i_data,
    input  wire logic    i_empty,
    output logic         o_pop,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    output t_out_word    o_out_word
);

    logic [DELIM_MAX-1:0] r_sent;
    logic [DELIM_MAX-1:0] n_sent;
    logic [DELIM_MAX-1:0] pend;
    logic [DELIM_MAX-1:0] first;
    logic [IDX_W-1:0]     pos;
    logic                 marker;
    logic                 final_word;
    logic                 accept;

    always_comb begin
        pend  = i_data.keep & ~r_sent;
        first = pend & (~pend + DELIM_MAX'(1));
        pos   = '0;
        for (int j = 0; j < DELIM_MAX; j++) begin
            if (first[j]) begin
                pos = IDX_W'(j);
            end
        end
    end

    // an empty mask is the end marker of a stream
    assign marker      = (i_data.keep == '0);
    assign final_word  = marker || (pend == first);
    assign o_out_valid = !i_empty;
    assign accept      = o_out_valid && i_out_ready;
    assign o_pop       = accept && final_word;

    assign o_out_word.out_byte   = marker ? 8'h00 : i_data.bytes[pos];
    assign o_out_word.byte_valid = !marker;
    assign o_out_word.run_last   = final_word;
    assign o_out_word.stream_end = final_word && i_data.stream_last;

    always_comb begin
        n_sent = r_sent;
        if (accept) begin
            n_sent = final_word ? '0 : (r_sent | first);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sent <= '0;
        end else begin
            r_sent <= n_sent;
        end
    end

endmodule

`default_nettype wire
